// File: rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper: bus operation
// codes, configuration register indexes and the transfer payload structs.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // widest ROM byte address the mapper can produce
  localparam int ROM_ADDR_BITS = 23;
  // default size of the internal RAM in bytes
  localparam int RAM_BYTES_DEF = 32768;

  // configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE_LOG2 = 2'd2;

  // bus operation codes
  typedef enum logic [1:0] {
    OP_ROM_READ  = 2'd0,
    OP_CTRL_WR   = 2'd1,
    OP_RAM_READ  = 2'd2,
    OP_RAM_WRITE = 2'd3
  } cbm_op_t;

  // one bus access
  typedef struct packed {
    cbm_op_t     operation;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } cbm_in_t;

  // one answer to a read
  typedef struct packed {
    logic [ROM_ADDR_BITS-1:0] rom_address;
    logic [7:0]               read_data;
    logic                     is_ram_result;
  } cbm_out_t;

endpackage

// File: rtl/core/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Cartridge memory bank controller with ROM bank mapping and internal RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an access (in_data) transfers on a clock edge with start
//   high and busy low. ROM reads and RAM reads each give one result; control
//   writes and RAM writes give none.
//   Result channel: out_strobe is high for one cycle with out_data in the cycle
//   after the access transfers. The receiver cannot stall, so nothing backs up.
//   Throughput is one access per cycle; an access may follow in the very next
//   cycle, and a RAM read right after a RAM write to the same byte sees the
//   new byte, since the single-port RAM commits the write at the transfer edge.
//   Configuration: cfg_we writes register cfg_index with cfg_wdata at once;
//   index 3 is ignored. Write it only while no access is in flight.
//   Reset: bank registers return to their defaults, and a clearing pass zeroes
//   the RAM one byte a cycle, during which busy is high and no access is taken.
//   Configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper
  import cbm_pkg::*;
#(
  parameter int RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  cbm_in_t               in_data,
  output logic                  out_strobe,
  output cbm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_BYTES - 1);
  localparam logic [4:0] ROM_K_MIN = 5'd15;
  localparam logic [4:0] ROM_K_MAX = 5'(ROM_ADDR_BITS);
  localparam logic [3:0] RAM_K_MIN = 4'd11;
  localparam logic [3:0] RAM_K_MAX = 4'd15;

  // configuration registers
  logic [4:0] rom_size_log2_r;
  logic       ram_present_r;
  logic [3:0] ram_size_log2_r;

  // bank state
  logic       ram_enable_r;
  logic [6:0] rom_bank_r;
  logic [7:0] ram_bank_r;

  // clearing pass
  logic              clearing_r;
  logic [RAM_AW-1:0] clr_addr_r;

  // result stage
  logic                     out_strobe_r;
  logic                     is_ram_r;
  logic                     rd_ok_r;
  logic [ROM_ADDR_BITS-1:0] rom_addr_r;
  logic [ROM_ADDR_BITS-1:0] rom_addr_nxt;

  // internal RAM
  logic [7:0]        mem [RAM_BYTES];
  logic [7:0]        mem_q_r;
  logic              mem_we;
  logic              mem_re;
  logic [RAM_AW-1:0] mem_addr;
  logic [7:0]        mem_wd;

  logic              acc;
  logic              ram_ok;
  logic [4:0]        rom_k;
  logic [3:0]        ram_k;
  logic [ROM_ADDR_BITS-1:0] rom_mask;
  logic [14:0]       ram_mask;
  logic [20:0]       ram_lin;
  logic [14:0]       ram_off15;
  logic [20:0]       rom_lin;

  assign busy   = clearing_r;
  assign acc    = start && !clearing_r;
  assign ram_ok = ram_enable_r && ram_present_r;

  // size masks from the clamped log2 sizes
  always_comb begin
    if (rom_size_log2_r < ROM_K_MIN)      rom_k = ROM_K_MIN;
    else if (rom_size_log2_r > ROM_K_MAX) rom_k = ROM_K_MAX;
    else                                  rom_k = rom_size_log2_r;
    if (ram_size_log2_r < RAM_K_MIN)      ram_k = RAM_K_MIN;
    else if (ram_size_log2_r > RAM_K_MAX) ram_k = RAM_K_MAX;
    else                                  ram_k = ram_size_log2_r;
    for (int i = 0; i < ROM_ADDR_BITS; i++) begin
      rom_mask[i] = 5'(i) < rom_k;
    end
    for (int j = 0; j < 15; j++) begin
      ram_mask[j] = 4'(j) < ram_k;
    end
  end

  // rom window mapping: bank 0 fixed low, selected bank high
  always_comb begin
    if (!in_data.bus_address[14]) rom_lin = {7'd0, in_data.bus_address[13:0]};
    else                          rom_lin = {rom_bank_r, in_data.bus_address[13:0]};
    rom_addr_nxt = {{(ROM_ADDR_BITS-21){1'b0}}, rom_lin} & rom_mask;
  end

  // ram offset: bank above the 8 KiB window, wrapped to the ram size
  assign ram_lin   = {ram_bank_r, in_data.bus_address[12:0]};
  assign ram_off15 = ram_lin[14:0] & ram_mask;

  // memory port: clearing pass first, then accesses
  always_comb begin
    mem_we   = clearing_r || (acc && in_data.operation == OP_RAM_WRITE && ram_ok);
    mem_re   = acc && in_data.operation == OP_RAM_READ;
    mem_addr = clearing_r ? clr_addr_r : ram_off15[RAM_AW-1:0];
    mem_wd   = clearing_r ? 8'h00 : in_data.write_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CLR_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_size_log2_r <= 5'd15;
      ram_present_r   <= 1'b0;
      ram_size_log2_r <= 4'd13;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_SIZE_LOG2: rom_size_log2_r <= cfg_wdata;
        CFG_RAM_PRESENT:   ram_present_r   <= cfg_wdata[0];
        CFG_RAM_SIZE_LOG2: ram_size_log2_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // control register writes by address range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      rom_bank_r   <= 7'd1;
      ram_bank_r   <= 8'd0;
    end else if (acc && in_data.operation == OP_CTRL_WR) begin
      case (in_data.bus_address[15:13])
        3'd0: ram_enable_r <= in_data.write_data[3:0] == 4'hA;
        3'd1: rom_bank_r   <= (in_data.write_data[6:0] == 7'd0) ? 7'd1
                                                                 : in_data.write_data[6:0];
        3'd2: ram_bank_r   <= in_data.write_data;
        default: ;
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= acc && (in_data.operation == OP_ROM_READ ||
                              in_data.operation == OP_RAM_READ);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      is_ram_r   <= in_data.operation == OP_RAM_READ;
      rd_ok_r    <= ram_ok;
      rom_addr_r <= rom_addr_nxt;
    end
  end

  always_comb begin
    out_strobe             = out_strobe_r;
    out_data.is_ram_result = is_ram_r;
    out_data.rom_address   = is_ram_r ? '0 : rom_addr_r;
    if (!is_ram_r)     out_data.read_data = 8'h00;
    else if (rd_ok_r)  out_data.read_data = mem_q_r;
    else               out_data.read_data = 8'hFF;
  end

endmodule

// File: rtl/core/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the cartridge bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker
  import cbm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input cbm_in_t               in_data,
  input logic                  out_strobe,
  input cbm_out_t              out_data
);

  logic rd_xfer;
  assign rd_xfer = start && !busy && (in_data.operation == OP_ROM_READ ||
                                      in_data.operation == OP_RAM_READ);

  // clearing pass always follows reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy)
    else $error("busy low right after reset");

  // once the clearing pass ends it does not come back
  a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose without reset");

  // every read transfer gives a result the next cycle
  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    rd_xfer |=> out_strobe)
    else $error("read transfer without result");

  // no result without a read transfer before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rd_xfer))
    else $error("result without read transfer");

  // unused fields of a result are zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.is_ram_result ? out_data.rom_address == '0
                                           : out_data.read_data == 8'h00))
    else $error("unused result field not zero");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
